// ===== hdl/smu_pkg.sv =====
// Shared types and constants for the scaled multiply/divide unit.
// Used by smu_div_stage and scaled_muldiv_unit; depends on nothing.
package smu_pkg;

    localparam int QW     = 64;
    localparam int DW     = 32;
    localparam int NSTAGE = QW;

    localparam logic [1:0] FN_MULADD = 2'd0;
    localparam logic [1:0] FN_DIVN   = 2'd1;
    localparam logic [1:0] FN_RATIO  = 2'd2;
    localparam logic [1:0] FN_ROUND  = 2'd3;

    localparam logic [QW-1:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [QW-1:0] NEG_MAX = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [1:0]    func;
        logic          fix;
        logic [DW-1:0] fix_res;
        logic [DW-1:0] fix_rem;
        logic          fix_err;
        logic          qneg;
        logic          rneg;
        logic [DW-1:0] dvs;
    } t_side;

endpackage

// ===== hdl/smu_div_stage.sv =====
// One registered step of the restoring divider: retires one quotient bit.
// Depends on smu_pkg for the sideband type and widths.
module smu_div_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  smu_pkg::t_side             i_side,
    input  logic [smu_pkg::QW-1:0]     i_q,
    input  logic [smu_pkg::DW-1:0]     i_rem,
    output logic                       o_valid,
    output smu_pkg::t_side             o_side,
    output logic [smu_pkg::QW-1:0]     o_q,
    output logic [smu_pkg::DW-1:0]     o_rem
);
    import smu_pkg::*;

    logic          r_valid;
    t_side         r_side;
    logic [QW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;
    logic          n_ge;

    always_comb begin
        n_trial = {i_rem, i_q[QW-1]};
        n_ge    = n_trial >= {1'b0, i_side.dvs};
        n_diff  = n_trial - {1'b0, i_side.dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_side <= i_side;
        r_q    <= {i_q[QW-2:0], n_ge};
        r_rem  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_q     = r_q;
    assign o_rem   = r_rem;

endmodule

// ===== hdl/scaled_muldiv_unit.sv =====
// Top level of the scaled multiply/divide unit: operand staging, multiplier,
// request decode, a 64-stage divider chain and the sign/round output stages.
// Depends on smu_pkg and smu_div_stage.
//
// Usage: a transaction is accepted at a rising edge with start high and busy
// low. Busy is high during reset and until the first rising edge after reset
// is released, so after that one transaction can be accepted in every cycle.
// Each transaction produces exactly one result on o_result, o_remainder and
// o_error, shown for one cycle with o_done high.
// Results leave in the order the transactions were accepted.
// The result passes through 69 register stages: one input register, one 32x32
// multiplier stage, one decode stage, 64 divider stages that each retire one
// quotient bit, and two stages for rounding and sign correction. The input
// register loads at the accepting edge, and o_done is the valid bit of the
// sign correction stage. Throughput is one transaction per cycle. Every
// function takes the same path, so the latency never varies.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall the unit, so there is no backpressure path.
module scaled_muldiv_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_func,
    input  logic signed [31:0]     i_x,
    input  logic signed [31:0]     i_n,
    input  logic signed [31:0]     i_addend,
    input  logic signed [31:0]     i_divisor,
    input  logic [30:0]            i_limit,
    output logic                   o_done,
    output logic signed [31:0]     o_result,
    output logic signed [31:0]     o_remainder,
    output logic                   o_error
);
    import smu_pkg::*;

    logic          r_busy;
    logic          r1_v;
    logic [1:0]    r1_func;
    logic [31:0]   r1_x, r1_n, r1_y, r1_d;
    logic [30:0]   r1_lim;

    logic          r2_v;
    logic [1:0]    r2_func;
    logic [31:0]   r2_x, r2_n, r2_y, r2_d, r2_ax, r2_an, r2_ad;
    logic [30:0]   r2_lim;
    logic [63:0]   r2_mag;

    logic [31:0]   n_ax, n_an, n_ad;

    logic          r3_v;
    t_side         r3_side;
    logic [QW-1:0] r3_q;

    t_side         n3_side;
    logic [QW-1:0] n3_q;
    logic          n_pneg;
    logic signed [65:0] n_p, n_a, n_b, n_nn;
    logic          n_c1, n_c2;

    logic          w_v    [0:NSTAGE];
    t_side         w_side [0:NSTAGE];
    logic [QW-1:0] w_q    [0:NSTAGE];
    logic [DW-1:0] w_rem  [0:NSTAGE];

    logic          r4_v;
    t_side         r4_side;
    logic [QW-1:0] r4_q;
    logic [DW-1:0] r4_rem;
    logic          n_round;
    logic [QW-1:0] n_qq;

    logic          r5_v;
    logic [31:0]   r5_res, r5_rem;
    logic          r5_err;
    logic [QW-1:0] n_sq;
    logic [DW-1:0] n_srem;
    logic          n_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r1_v   <= start && !r_busy;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
        end
        r1_func <= i_func;
        r1_x    <= i_x;
        r1_n    <= i_n;
        r1_y    <= i_addend;
        r1_d    <= i_divisor;
        r1_lim  <= i_limit;
    end

    assign busy = r_busy;

    always_comb begin
        n_ax = r1_x[31] ? 32'(-r1_x) : r1_x;
        n_an = r1_n[31] ? 32'(-r1_n) : r1_n;
        n_ad = r1_d[31] ? 32'(-r1_d) : r1_d;
    end

    always_ff @(posedge i_clk) begin
        r2_func <= r1_func;
        r2_x    <= r1_x;
        r2_n    <= r1_n;
        r2_y    <= r1_y;
        r2_d    <= r1_d;
        r2_lim  <= r1_lim;
        r2_ax   <= n_ax;
        r2_an   <= n_an;
        r2_ad   <= n_ad;
        r2_mag  <= n_ax * n_an;
    end

    always_comb begin
        n_pneg = r2_x[31] ^ r2_n[31];
        n_p    = n_pneg ? -$signed({2'b00, r2_mag}) : $signed({2'b00, r2_mag});
        n_nn   = $signed({34'd0, r2_an});
        n_a    = $signed({35'd0, r2_lim}) - $signed({{34{r2_y[31]}}, r2_y});
        n_b    = $signed({35'd0, r2_lim}) + $signed({{34{r2_y[31]}}, r2_y});
        n_c1   = n_a[65] ? (n_p <= n_a + n_nn - 66'sd1) : (n_p <= n_a);
        n_c2   = n_b[65] ? (-n_p <= n_b + n_nn - 66'sd1) : (-n_p <= n_b);

        n3_side         = '0;
        n3_side.func    = r2_func;
        n3_q            = r2_mag;
        unique case (r2_func)
            FN_MULADD: begin
                n3_side.fix = 1'b1;
                if (r2_n == 32'd0) begin
                    n3_side.fix_res = r2_y;
                end else if (n_c1 && n_c2) begin
                    n3_side.fix_res = n_p[31:0] + r2_y;
                end else begin
                    n3_side.fix_err = 1'b1;
                end
            end
            FN_DIVN: begin
                n3_q         = {32'd0, r2_ax};
                n3_side.dvs  = r2_an;
                n3_side.qneg = n_pneg;
                n3_side.rneg = r2_x[31];
                if (r2_n == 32'd0) begin
                    n3_side.fix     = 1'b1;
                    n3_side.fix_rem = r2_x;
                    n3_side.fix_err = 1'b1;
                end
            end
            FN_RATIO: begin
                n3_side.dvs  = r2_ad;
                n3_side.qneg = n_pneg ^ r2_d[31];
                n3_side.rneg = n_pneg;
                if (r2_x == 32'd0) begin
                    n3_side.fix = 1'b1;
                end else if (r2_d == 32'd0) begin
                    n3_side.fix     = 1'b1;
                    n3_side.fix_err = 1'b1;
                end
            end
            FN_ROUND: begin
                n3_side.dvs  = r2_d;
                n3_side.qneg = n_pneg;
                if (r2_x == 32'd0 || r2_n == r2_d) begin
                    n3_side.fix     = 1'b1;
                    n3_side.fix_res = r2_x;
                end else if (r2_d == 32'd0) begin
                    n3_side.fix     = 1'b1;
                    n3_side.fix_err = 1'b1;
                end
            end
            default: begin
                n3_side.fix = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_side <= n3_side;
        r3_q    <= n3_q;
    end

    assign w_v[0]    = r3_v;
    assign w_side[0] = r3_side;
    assign w_q[0]    = r3_q;
    assign w_rem[0]  = '0;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_div
        smu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_side  (w_side[k]),
            .i_q     (w_q[k]),
            .i_rem   (w_rem[k]),
            .o_valid (w_v[k+1]),
            .o_side  (w_side[k+1]),
            .o_q     (w_q[k+1]),
            .o_rem   (w_rem[k+1])
        );
    end

    always_comb begin
        n_round = ({w_rem[NSTAGE], 1'b0} >= {1'b0, w_side[NSTAGE].dvs})
                  && (w_side[NSTAGE].func == FN_ROUND);
        n_qq    = w_q[NSTAGE] + {{(QW-1){1'b0}}, n_round};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r4_v <= w_v[NSTAGE];
            r5_v <= r4_v;
        end
        r4_side <= w_side[NSTAGE];
        r4_q    <= n_qq;
        r4_rem  <= w_rem[NSTAGE];
    end

    always_comb begin
        n_sq   = r4_side.qneg ? QW'(-r4_q) : r4_q;
        n_srem = r4_side.rneg ? DW'(-r4_rem) : r4_rem;
        n_fits = r4_side.qneg ? (r4_q <= NEG_MAX) : (r4_q <= POS_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (r4_side.fix) begin
            r5_res <= r4_side.fix_res;
            r5_rem <= r4_side.fix_rem;
            r5_err <= r4_side.fix_err;
        end else begin
            r5_res <= n_sq[31:0];
            r5_rem <= (r4_side.func == FN_ROUND) ? 32'd0 : n_srem;
            r5_err <= !n_fits;
        end
    end

    assign o_done      = r5_v;
    assign o_result    = r5_res;
    assign o_remainder = r5_rem;
    assign o_error     = r5_err;

endmodule
